[hw/rtl/sfrt_pkg.sv]
// ----------------------------------------------------------------------------
// sfrt_pkg
// Shared types and constants of the sequential fault run tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package sfrt_pkg;

  localparam int PAGE_W         = 36;
  localparam int TIME_W         = 32;
  localparam int MAX_RUNS       = 15;
  localparam int SLOTS          = MAX_RUNS + 1;
  localparam int SLOT_W         = $clog2(SLOTS);
  localparam int HIST_D         = 4;
  localparam int HPTR_W         = $clog2(HIST_D);
  localparam int MIN_RUN_LENGTH = 16;
  localparam int GUARD_PAGES    = 4;
  localparam int OUTQ_DEPTH     = 4;
  localparam int INQ_DEPTH      = 2;

  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [TIME_W-1:0] ftime_t;
  typedef logic [SLOT_W-1:0] slot_t;

  localparam page_t PAGE_MAX = '1;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  typedef enum logic {
    OP_FAULT = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ACT_EXT_UP   = 3'd0,
    ACT_EXT_DOWN = 3'd1,
    ACT_SPLIT    = 3'd2,
    ACT_REFRESH  = 3'd3,
    ACT_NEW      = 3'd4,
    ACT_CAND     = 3'd5,
    ACT_NO_CAND  = 3'd6
  } action_e;

  typedef struct packed {
    op_e   op;
    page_t page;
  } req_t;

  typedef struct packed {
    action_e    action;
    page_t      lo;
    page_t      hi;
    logic [1:0] dir;
    logic       dropped;
    logic       last;
  } res_t;

endpackage

`default_nettype wire

[hw/rtl/sfrt_front.sv]
// ----------------------------------------------------------------------------
// sfrt_front
// Request intake: decodes the operation and buffers requests for the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module sfrt_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push,
  output      logic                  full,
  input  wire logic                  operation_i,
  input  wire sfrt_pkg::page_t       fault_page_i,
  output      logic                  req_valid_o,
  output      sfrt_pkg::req_t        req_o,
  input  wire logic                  req_pop_i
);

  localparam int PTR_W = $clog2(sfrt_pkg::INQ_DEPTH);
  localparam int CNT_W = $clog2(sfrt_pkg::INQ_DEPTH + 1);

  sfrt_pkg::req_t   mem_q [sfrt_pkg::INQ_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             wr_en, rd_en;
  sfrt_pkg::req_t   req_in;

  assign full        = (cnt_q == CNT_W'(sfrt_pkg::INQ_DEPTH));
  assign req_valid_o = (cnt_q != '0);
  assign req_o       = mem_q[rd_q];
  assign wr_en       = push && !full;
  assign rd_en       = req_pop_i && req_valid_o;

  always_comb begin
    req_in.op   = operation_i ? sfrt_pkg::OP_QUERY : sfrt_pkg::OP_FAULT;
    // the page means nothing for a query
    req_in.page = operation_i ? '0 : fault_page_i;
  end

  always_comb begin
    wr_d  = wr_en ? PTR_W'((wr_q + 1'b1) % sfrt_pkg::INQ_DEPTH) : wr_q;
    rd_d  = rd_en ? PTR_W'((rd_q + 1'b1) % sfrt_pkg::INQ_DEPTH) : rd_q;
    cnt_d = cnt_q + CNT_W'(wr_en) - CNT_W'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= req_in;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sfrt_outq.sv]
// ----------------------------------------------------------------------------
// sfrt_outq
// Result queue between the engine and the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module sfrt_outq (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           res_push_i,
  input  wire sfrt_pkg::res_t res_i,
  output      logic           res_full_o,
  output      logic           empty,
  input  wire logic           pop,
  output      sfrt_pkg::res_t head_o
);

  localparam int PTR_W = $clog2(sfrt_pkg::OUTQ_DEPTH);
  localparam int CNT_W = $clog2(sfrt_pkg::OUTQ_DEPTH + 1);

  sfrt_pkg::res_t   mem_q [sfrt_pkg::OUTQ_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             wr_en, rd_en;

  assign res_full_o = (cnt_q == CNT_W'(sfrt_pkg::OUTQ_DEPTH));
  assign empty      = (cnt_q == '0);
  assign head_o     = mem_q[rd_q];
  assign wr_en      = res_push_i && !res_full_o;
  assign rd_en      = pop && !empty;

  always_comb begin
    wr_d  = wr_en ? PTR_W'((wr_q + 1'b1) % sfrt_pkg::OUTQ_DEPTH) : wr_q;
    rd_d  = rd_en ? PTR_W'((rd_q + 1'b1) % sfrt_pkg::OUTQ_DEPTH) : rd_q;
    cnt_d = cnt_q + CNT_W'(wr_en) - CNT_W'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= res_i;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sfrt_engine.sv]
// ----------------------------------------------------------------------------
// sfrt_engine
// Run table, age list and the sequencer that carries out faults and queries.
// ----------------------------------------------------------------------------
`default_nettype none

module sfrt_engine (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           req_valid_i,
  input  wire sfrt_pkg::req_t req_i,
  output      logic           req_pop_o,
  input  wire logic           res_full_i,
  output      logic           res_push_o,
  output      sfrt_pkg::res_t res_o
);

  localparam int SLOTS  = sfrt_pkg::SLOTS;
  localparam int SLOT_W = sfrt_pkg::SLOT_W;
  localparam int HIST_D = sfrt_pkg::HIST_D;
  localparam int HPTR_W = sfrt_pkg::HPTR_W;
  localparam int PAGE_W = sfrt_pkg::PAGE_W;
  localparam int IDX_W  = SLOT_W + 1;
  localparam int LEN_W  = PAGE_W + 1;
  localparam sfrt_pkg::slot_t LAST_SLOT = SLOT_W'(SLOTS - 1);

  typedef enum logic [12:0] {
    S_IDLE    = 13'h0001,
    S_MATCH   = 13'h0002,
    S_RESOLVE = 13'h0004,
    S_REC     = 13'h0008,
    S_INS     = 13'h0010,
    S_MERGE   = 13'h0020,
    S_CUT     = 13'h0040,
    S_NEWRUN  = 13'h0080,
    S_VICTIM  = 13'h0100,
    S_VDROP   = 13'h0200,
    S_EMIT    = 13'h0400,
    S_QSCAN   = 13'h0800,
    S_QEND    = 13'h1000
  } state_e;

  state_e state_q, state_d;

  // run table
  logic [SLOTS-1:0]       valid_q, valid_d;
  sfrt_pkg::page_t        low_q  [SLOTS];
  sfrt_pkg::page_t        low_d  [SLOTS];
  sfrt_pkg::page_t        high_q [SLOTS];
  sfrt_pkg::page_t        high_d [SLOTS];
  logic [1:0]             dir_q  [SLOTS];
  logic [1:0]             dir_d  [SLOTS];
  sfrt_pkg::ftime_t       hist_q [SLOTS][HIST_D];
  sfrt_pkg::ftime_t       hist_d [SLOTS][HIST_D];
  logic [HPTR_W-1:0]      ptr_q  [SLOTS];
  logic [HPTR_W-1:0]      ptr_d  [SLOTS];
  sfrt_pkg::ftime_t       clock_q, clock_d;

  // age list, newest oldest-fault first
  sfrt_pkg::slot_t        age_q [SLOTS];
  sfrt_pkg::slot_t        age_d [SLOTS];
  logic [IDX_W-1:0]       age_cnt_q, age_cnt_d;

  // per-request working registers
  logic [IDX_W-1:0]       idx_q, idx_d;
  sfrt_pkg::page_t        vpn_q, vpn_d;
  sfrt_pkg::slot_t        a_q, a_d, b_q, b_d, hit_q, hit_d;
  logic                   a_v_q, a_v_d, b_v_q, b_v_d, hit_v_q, hit_v_d;
  sfrt_pkg::slot_t        cand_q, cand_d;
  logic                   up_q, up_d;
  sfrt_pkg::slot_t        rec_q, rec_d;
  sfrt_pkg::ftime_t       ins_t_q, ins_t_d;
  logic                   ret_merge_q, ret_merge_d;
  sfrt_pkg::slot_t        new_q, new_d;
  sfrt_pkg::slot_t        vic_q, vic_d;
  logic                   vic_v_q, vic_v_d;
  sfrt_pkg::ftime_t       vic_t_q, vic_t_d;
  sfrt_pkg::page_t        vic_lo_q, vic_lo_d;
  logic                   drop_q, drop_d;
  sfrt_pkg::res_t         res_q, res_d;
  logic                   pend_v_q, pend_v_d;
  sfrt_pkg::res_t         pend_q, pend_d;

  sfrt_pkg::ftime_t       newest_w [SLOTS];
  sfrt_pkg::ftime_t       oldest_w [SLOTS];
  sfrt_pkg::slot_t        free_slot;
  logic                   free_v;
  logic [IDX_W-1:0]       valid_cnt;

  for (genvar g = 0; g < SLOTS; g++) begin : g_time
    assign newest_w[g] = hist_q[g][ptr_q[g]];
    assign oldest_w[g] = hist_q[g][HPTR_W'(ptr_q[g] + 1'b1)];
  end

  // first free slot and occupancy
  always_comb begin
    free_slot = '0;
    free_v    = 1'b0;
    valid_cnt = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (!valid_q[k]) begin
        free_slot = SLOT_W'(k);
        free_v    = 1'b1;
      end
      valid_cnt = valid_cnt + IDX_W'(valid_q[k]);
    end
  end

  always_comb begin
    sfrt_pkg::slot_t   i;
    sfrt_pkg::slot_t   c;
    logic              up;
    logic [HPTR_W-1:0] np;
    logic              rm_en;
    sfrt_pkg::slot_t   rm_slot;
    logic              rm_found;
    logic [IDX_W-1:0]  rm_pos;
    logic [LEN_W-1:0]  len;
    logic              elig;
    sfrt_pkg::res_t    item;
    logic              ins_here;

    state_d     = state_q;
    valid_d     = valid_q;
    low_d       = low_q;
    high_d      = high_q;
    dir_d       = dir_q;
    hist_d      = hist_q;
    ptr_d       = ptr_q;
    clock_d     = clock_q;
    age_d       = age_q;
    age_cnt_d   = age_cnt_q;
    idx_d       = idx_q;
    vpn_d       = vpn_q;
    a_d         = a_q;
    b_d         = b_q;
    hit_d       = hit_q;
    a_v_d       = a_v_q;
    b_v_d       = b_v_q;
    hit_v_d     = hit_v_q;
    cand_d      = cand_q;
    up_d        = up_q;
    rec_d       = rec_q;
    ins_t_d     = ins_t_q;
    ret_merge_d = ret_merge_q;
    new_d       = new_q;
    vic_d       = vic_q;
    vic_v_d     = vic_v_q;
    vic_t_d     = vic_t_q;
    vic_lo_d    = vic_lo_q;
    drop_d      = drop_q;
    res_d       = res_q;
    pend_v_d    = pend_v_q;
    pend_d      = pend_q;
    req_pop_o   = 1'b0;
    res_push_o  = 1'b0;
    res_o       = res_q;
    rm_en       = 1'b0;
    rm_slot     = '0;
    rm_found    = 1'b0;
    rm_pos      = '0;
    i           = idx_q[SLOT_W-1:0];
    c           = '0;
    up          = 1'b0;
    np          = '0;
    len         = '0;
    elig        = 1'b0;
    item        = '0;
    ins_here    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          req_pop_o = 1'b1;
          vpn_d     = req_i.page;
          idx_d     = '0;
          drop_d    = 1'b0;
          a_v_d     = 1'b0;
          b_v_d     = 1'b0;
          hit_v_d   = 1'b0;
          pend_v_d  = 1'b0;
          state_d   = (req_i.op == sfrt_pkg::OP_QUERY) ? S_QSCAN : S_MATCH;
        end
      end

      S_MATCH: begin
        if (valid_q[i]) begin
          if (vpn_q != '0 && high_q[i] == vpn_q - 1'b1 && dir_q[i] != sfrt_pkg::DIR_DOWN) begin
            a_d   = i;
            a_v_d = 1'b1;
          end
          if (vpn_q != sfrt_pkg::PAGE_MAX && low_q[i] == vpn_q + 1'b1 &&
              dir_q[i] != sfrt_pkg::DIR_UP) begin
            b_d   = i;
            b_v_d = 1'b1;
          end
          if (!hit_v_q && low_q[i] <= vpn_q && vpn_q <= high_q[i]) begin
            hit_d   = i;
            hit_v_d = 1'b1;
          end
        end
        idx_d   = idx_q + 1'b1;
        state_d = (i == LAST_SLOT) ? S_RESOLVE : S_MATCH;
      end

      S_RESOLVE: begin
        res_d.lo  = vpn_q;
        res_d.hi  = vpn_q;
        res_d.dir = sfrt_pkg::DIR_NONE;
        if (a_v_q && b_v_q) begin
          drop_d = 1'b1;
          if (newest_w[a_q] < newest_w[b_q]) begin
            valid_d[a_q] = 1'b0;
            rm_en        = 1'b1;
            rm_slot      = a_q;
            c            = b_q;
            up           = 1'b0;
          end else begin
            valid_d[b_q] = 1'b0;
            rm_en        = 1'b1;
            rm_slot      = b_q;
            c            = a_q;
            up           = 1'b1;
          end
        end else begin
          c  = a_v_q ? a_q : b_q;
          up = a_v_q;
        end
        if (a_v_q || b_v_q) begin
          if (up) begin
            high_d[c] = vpn_q;
          end else begin
            low_d[c] = vpn_q;
          end
          cand_d      = c;
          up_d        = up;
          rec_d       = c;
          ret_merge_d = 1'b1;
          state_d     = S_REC;
        end else if (hit_v_q && dir_q[hit_q] == sfrt_pkg::DIR_NONE) begin
          res_d.action = sfrt_pkg::ACT_REFRESH;
          rec_d        = hit_q;
          ret_merge_d  = 1'b0;
          state_d      = S_REC;
        end else if (hit_v_q) begin
          state_d = S_CUT;
        end else begin
          res_d.action = sfrt_pkg::ACT_NEW;
          state_d      = S_NEWRUN;
        end
      end

      S_REC: begin
        np                = HPTR_W'(ptr_q[rec_q] + 1'b1);
        ptr_d[rec_q]      = np;
        hist_d[rec_q][np] = clock_q;
        ins_t_d           = hist_q[rec_q][HPTR_W'(np + 1'b1)];
        rm_en             = 1'b1;
        rm_slot           = rec_q;
        idx_d             = '0;
        state_d           = S_INS;
      end

      S_INS: begin
        // insert behind every entry whose oldest time is not older
        ins_here = (idx_q >= age_cnt_q) || (oldest_w[age_q[i]] < ins_t_q);
        if (ins_here) begin
          if (age_cnt_q < IDX_W'(SLOTS)) begin
            for (int k = 0; k < SLOTS; k++) begin
              if (IDX_W'(k) > idx_q) begin
                age_d[k] = age_q[k-1];
              end else if (IDX_W'(k) == idx_q) begin
                age_d[k] = rec_q;
              end
            end
            age_cnt_d = age_cnt_q + 1'b1;
          end
          idx_d   = '0;
          state_d = ret_merge_q ? S_MERGE : S_EMIT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_MERGE: begin
        if (i != cand_q && valid_q[i] && low_q[i] <= vpn_q && vpn_q <= high_q[i]) begin
          valid_d[i] = 1'b0;
          rm_en      = 1'b1;
          rm_slot    = i;
          drop_d     = 1'b1;
        end
        idx_d = idx_q + 1'b1;
        if (i == LAST_SLOT) begin
          dir_d[cand_q] = up_q ? sfrt_pkg::DIR_UP : sfrt_pkg::DIR_DOWN;
          res_d.action  = up_q ? sfrt_pkg::ACT_EXT_UP : sfrt_pkg::ACT_EXT_DOWN;
          res_d.lo      = low_q[cand_q];
          res_d.hi      = high_q[cand_q];
          res_d.dir     = up_q ? sfrt_pkg::DIR_UP : sfrt_pkg::DIR_DOWN;
          state_d       = S_EMIT;
        end
      end

      S_CUT: begin
        if (dir_q[hit_q] == sfrt_pkg::DIR_UP) begin
          if (vpn_q <= low_q[hit_q]) begin
            valid_d[hit_q] = 1'b0;
            rm_en          = 1'b1;
            rm_slot        = hit_q;
            drop_d         = 1'b1;
          end else begin
            high_d[hit_q] = vpn_q - 1'b1;
          end
        end else begin
          if (vpn_q >= high_q[hit_q]) begin
            valid_d[hit_q] = 1'b0;
            rm_en          = 1'b1;
            rm_slot        = hit_q;
            drop_d         = 1'b1;
          end else begin
            low_d[hit_q] = vpn_q + 1'b1;
          end
        end
        res_d.action = sfrt_pkg::ACT_SPLIT;
        state_d      = S_NEWRUN;
      end

      S_NEWRUN: begin
        if (!free_v) begin
          state_d = S_EMIT;
        end else begin
          valid_d[free_slot] = 1'b1;
          low_d[free_slot]   = vpn_q;
          high_d[free_slot]  = vpn_q;
          dir_d[free_slot]   = sfrt_pkg::DIR_NONE;
          for (int k = 0; k < HIST_D; k++) begin
            hist_d[free_slot][k] = '0;
          end
          hist_d[free_slot][0] = clock_q;
          ptr_d[free_slot]     = '0;
          if (age_cnt_q < IDX_W'(SLOTS)) begin
            age_d[age_cnt_q[SLOT_W-1:0]] = free_slot;
            age_cnt_d                    = age_cnt_q + 1'b1;
          end
          new_d       = free_slot;
          rec_d       = free_slot;
          ret_merge_d = 1'b0;
          idx_d       = '0;
          vic_v_d     = 1'b0;
          // the new run brings the table over its limit
          state_d     = (valid_cnt >= IDX_W'(sfrt_pkg::MAX_RUNS)) ? S_VICTIM : S_REC;
        end
      end

      S_VICTIM: begin
        if (valid_q[i]) begin
          if (!vic_v_q || newest_w[i] < vic_t_q ||
              (newest_w[i] == vic_t_q && low_q[i] < vic_lo_q)) begin
            vic_d    = i;
            vic_v_d  = 1'b1;
            vic_t_d  = newest_w[i];
            vic_lo_d = low_q[i];
          end
        end
        idx_d   = idx_q + 1'b1;
        state_d = (i == LAST_SLOT) ? S_VDROP : S_VICTIM;
      end

      S_VDROP: begin
        if (vic_v_q) begin
          valid_d[vic_q] = 1'b0;
          rm_en          = 1'b1;
          rm_slot        = vic_q;
          drop_d         = 1'b1;
        end
        state_d = (vic_v_q && vic_q == new_q) ? S_EMIT : S_REC;
      end

      S_EMIT: begin
        if (!res_full_i) begin
          res_push_o    = 1'b1;
          res_o         = res_q;
          res_o.dropped = drop_q;
          res_o.last    = 1'b1;
          clock_d       = clock_q + 1'b1;
          state_d       = S_IDLE;
        end
      end

      S_QSCAN: begin
        if (idx_q >= age_cnt_q) begin
          state_d = S_QEND;
        end else begin
          c    = age_q[i];
          len  = {1'b0, high_q[c]} - {1'b0, low_q[c]} + 1'b1;
          elig = valid_q[c] && len >= LEN_W'(sfrt_pkg::MIN_RUN_LENGTH) &&
                 len > LEN_W'(sfrt_pkg::GUARD_PAGES) &&
                 (dir_q[c] == sfrt_pkg::DIR_UP || dir_q[c] == sfrt_pkg::DIR_DOWN);
          item.action = sfrt_pkg::ACT_CAND;
          item.dir    = dir_q[c];
          if (dir_q[c] == sfrt_pkg::DIR_UP) begin
            item.lo = low_q[c];
            item.hi = high_q[c] - PAGE_W'(sfrt_pkg::GUARD_PAGES);
          end else begin
            item.lo = high_q[c];
            item.hi = low_q[c] + PAGE_W'(sfrt_pkg::GUARD_PAGES);
          end
          // hold one candidate back so the final one can carry last
          if (!(elig && pend_v_q && res_full_i)) begin
            if (elig) begin
              if (pend_v_q) begin
                res_push_o = 1'b1;
                res_o      = pend_q;
              end
              pend_d   = item;
              pend_v_d = 1'b1;
            end
            idx_d = idx_q + 1'b1;
          end
        end
      end

      S_QEND: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          if (pend_v_q) begin
            res_o = pend_q;
          end else begin
            res_o        = '0;
            res_o.action = sfrt_pkg::ACT_NO_CAND;
          end
          res_o.last = 1'b1;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // take one slot out of the age list, closing the gap
    if (rm_en) begin
      for (int k = 0; k < SLOTS; k++) begin
        if (!rm_found && IDX_W'(k) < age_cnt_q && age_q[k] == rm_slot) begin
          rm_found = 1'b1;
          rm_pos   = IDX_W'(k);
        end
      end
      if (rm_found) begin
        for (int k = 0; k < SLOTS - 1; k++) begin
          if (IDX_W'(k) >= rm_pos) begin
            age_d[k] = age_q[k+1];
          end
        end
        age_cnt_d = age_cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      valid_q   <= '0;
      age_cnt_q <= '0;
      clock_q   <= '0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      age_cnt_q <= age_cnt_d;
      clock_q   <= clock_d;
    end
  end

  always_ff @(posedge clk_i) begin
    low_q       <= low_d;
    high_q      <= high_d;
    dir_q       <= dir_d;
    hist_q      <= hist_d;
    ptr_q       <= ptr_d;
    age_q       <= age_d;
    idx_q       <= idx_d;
    vpn_q       <= vpn_d;
    a_q         <= a_d;
    b_q         <= b_d;
    hit_q       <= hit_d;
    a_v_q       <= a_v_d;
    b_v_q       <= b_v_d;
    hit_v_q     <= hit_v_d;
    cand_q      <= cand_d;
    up_q        <= up_d;
    rec_q       <= rec_d;
    ins_t_q     <= ins_t_d;
    ret_merge_q <= ret_merge_d;
    new_q       <= new_d;
    vic_q       <= vic_d;
    vic_v_q     <= vic_v_d;
    vic_t_q     <= vic_t_d;
    vic_lo_q    <= vic_lo_d;
    drop_q      <= drop_d;
    res_q       <= res_d;
    pend_v_q    <= pend_v_d;
    pend_q      <= pend_d;
  end

endmodule

`default_nettype wire

[hw/rtl/sequential_fault_run_tracker.sv]
// A fault takes table scans of 16 slots for match, merge and victim, plus a walk of
// the age list per recorded fault; a query walks the age list. One request is in
// the engine at a time; a 2-entry request queue and a 4-entry result queue decouple
// both sides. Reset clears the run valid bits, the age list, the fault clock and
// both queues; there is no clearing pass.
// ----------------------------------------------------------------------------
// sequential_fault_run_tracker
// Tracks runs of page faults and lists long runs as eviction candidates.
// ----------------------------------------------------------------------------
`default_nettype none

module sequential_fault_run_tracker (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    push,
  output      logic                    full,
  input  wire logic                    operation_i,
  input  wire logic [35:0]             fault_page_i,
  output      logic                    empty,
  input  wire logic                    pop,
  output      logic [2:0]              action_o,
  output      logic [35:0]             range_low_o,
  output      logic [35:0]             range_high_o,
  output      logic [1:0]              direction_o,
  output      logic                    dropped_run_o,
  output      logic                    last_o
);

  logic           req_valid;
  sfrt_pkg::req_t req;
  logic           req_pop;
  logic           res_push;
  logic           res_full;
  sfrt_pkg::res_t res;
  sfrt_pkg::res_t head;

  sfrt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .operation_i  (operation_i),
    .fault_page_i (fault_page_i),
    .req_valid_o  (req_valid),
    .req_o        (req),
    .req_pop_i    (req_pop)
  );

  sfrt_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .req_pop_o   (req_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  sfrt_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_push_i (res_push),
    .res_i      (res),
    .res_full_o (res_full),
    .empty      (empty),
    .pop        (pop),
    .head_o     (head)
  );

  assign action_o      = head.action;
  assign range_low_o   = head.lo;
  assign range_high_o  = head.hi;
  assign direction_o   = head.dir;
  assign dropped_run_o = head.dropped;
  assign last_o        = head.last;

endmodule

`default_nettype wire

[hw/rtl/sfrt_checker.sv]
// ----------------------------------------------------------------------------
// sfrt_checker
// Port-level checks of the result stream of the fault run tracker.
// ----------------------------------------------------------------------------
`default_nettype none

module sfrt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [2:0]  action_o,
  input wire logic [35:0] range_low_o,
  input wire logic [35:0] range_high_o,
  input wire logic [1:0]  direction_o,
  input wire logic        dropped_run_o,
  input wire logic        last_o
);

  logic fault_res, query_res;

  assign fault_res = !empty && action_o != sfrt_pkg::ACT_CAND &&
                     action_o != sfrt_pkg::ACT_NO_CAND;
  assign query_res = !empty && (action_o == sfrt_pkg::ACT_CAND ||
                                action_o == sfrt_pkg::ACT_NO_CAND);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(action_o) && $stable(range_low_o) &&
                       $stable(last_o))
    else $error("result changed while stalled");

  // a fault gives exactly one result
  a_fault_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_res |-> last_o)
    else $error("fault result without last");

  // a query never drops runs
  a_query_nodrop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_res |-> !dropped_run_o)
    else $error("query result reports a dropped run");

  a_cand_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && action_o == sfrt_pkg::ACT_CAND |->
      direction_o == sfrt_pkg::DIR_UP || direction_o == sfrt_pkg::DIR_DOWN)
    else $error("candidate without a direction");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && action_o == sfrt_pkg::ACT_NO_CAND |->
      last_o && range_low_o == '0 && range_high_o == '0 &&
      direction_o == sfrt_pkg::DIR_NONE)
    else $error("empty query result malformed");

endmodule

bind sequential_fault_run_tracker sfrt_checker u_sfrt_checker (.*);

`default_nettype wire
